// ===== src/reconnect_backoff_supervisor_defines.svh =====
// Assertion macros for the reconnect backoff supervisor.
`ifndef RECONNECT_BACKOFF_SUPERVISOR_DEFINES_SVH
`define RECONNECT_BACKOFF_SUPERVISOR_DEFINES_SVH

// same-cycle implication
`define RBS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbs assertion failed");

// next-cycle implication
`define RBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbs assertion failed");

`endif

// ===== src/rbs_pkg.sv =====
// Package for the reconnect backoff supervisor: types, codes and defaults.
`timescale 1ns / 1ps
package rbs_pkg;

  localparam int SHIFT_LIMIT_DEFAULT = 20;

  localparam logic [1:0] REG_INITIAL_BACKOFF = 2'd0;
  localparam logic [1:0] REG_MAX_BACKOFF     = 2'd1;
  localparam logic [1:0] REG_MAX_RETRIES     = 2'd2;
  localparam logic [1:0] REG_SLEEP_WAKE      = 2'd3;

  localparam logic [31:0] INITIAL_BACKOFF_RESET = 32'd2000;
  localparam logic [31:0] MAX_BACKOFF_RESET     = 32'd60000;
  localparam logic [7:0]  MAX_RETRIES_RESET     = 8'd5;
  localparam logic [31:0] SLEEP_WAKE_RESET      = 32'd300000;

  localparam logic [2:0] CODE_IDLE       = 3'd0;
  localparam logic [2:0] CODE_WAITING    = 3'd1;
  localparam logic [2:0] CODE_CONNECTING = 3'd2;
  localparam logic [2:0] CODE_CONNECTED  = 3'd3;
  localparam logic [2:0] CODE_SLEEPING   = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'b0001,
    ST_WAITING   = 4'b0010,
    ST_CONNECTED = 4'b0100,
    ST_SLEEPING  = 4'b1000
  } state_t;

  function automatic logic [2:0] state_code(input state_t s);
    logic [2:0] c;
    unique case (s)
      ST_IDLE:      c = CODE_IDLE;
      ST_WAITING:   c = CODE_WAITING;
      ST_CONNECTED: c = CODE_CONNECTED;
      ST_SLEEPING:  c = CODE_SLEEPING;
      default:      c = CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

// ===== src/reconnect_backoff_supervisor.sv =====
// Top level of the reconnect backoff supervisor: poll register, state update, result register.
`timescale 1ns / 1ps
`include "reconnect_backoff_supervisor_defines.svh"
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------------
//  in      | in_valid, in_stall | time_now_ms, upstream_up, link_up, attempt_ok
//  out     | out_valid,out_stall| conn_state, attempt_issued, just_connected, usable,
//          |                    | retries_done, scheduled_delay_ms
//  cfg     | cfg_we             | cfg_index, cfg_data
//
//  One beat per cycle while the output is not stalled; each poll that is taken reaches the output.
//  The state update (compare, saturating count, backoff shift and cap) sits in one
//  stage between the poll register and the result register.
//  Synchronous reset restores the default configuration and the idle state.
//  A stalled output holds the poll register; in_stall is then raised while it holds a poll.
module reconnect_backoff_supervisor
  import rbs_pkg::*;
#(
  parameter int SHIFT_LIMIT = SHIFT_LIMIT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] time_now_ms,
  input  logic        upstream_up,
  input  logic        link_up,
  input  logic        attempt_ok,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  conn_state,
  output logic        attempt_issued,
  output logic        just_connected,
  output logic        usable,
  output logic [7:0]  retries_done,
  output logic [31:0] scheduled_delay_ms
);

  localparam int WIDE_W = 32 + SHIFT_LIMIT;
  localparam logic [7:0] SHIFT_MAX = 8'(SHIFT_LIMIT);

  logic [31:0] base_delay_ms;
  logic [31:0] delay_cap_ms;
  logic [7:0]  max_retries;
  logic [31:0] sleep_wake_ms;

  logic        poll_valid;
  logic [31:0] poll_time;
  logic        poll_up;
  logic        poll_link;
  logic        poll_ok;

  state_t      mode, mode_next;
  logic [7:0]  fail_count, fail_count_next;
  logic [31:0] retry_due_time, retry_due_time_next;
  logic [31:0] mode_entry_time, mode_entry_time_next;

  logic        out_load;
  logic        attempt, failure, wake_clear, joined;
  logic [7:0]  fc_base, fc_inc, shift_raw, shift;
  logic [31:0] due_diff, wake_diff, delay, delay_out;
  logic [WIDE_W-1:0] wide_delay, wide_max;

  assign out_load = poll_valid && (!out_valid || !out_stall);
  assign in_stall = poll_valid && !out_load;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      base_delay_ms <= INITIAL_BACKOFF_RESET;
      delay_cap_ms  <= MAX_BACKOFF_RESET;
      max_retries   <= MAX_RETRIES_RESET;
      sleep_wake_ms <= SLEEP_WAKE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INITIAL_BACKOFF: base_delay_ms <= cfg_data;
        REG_MAX_BACKOFF:     delay_cap_ms  <= cfg_data;
        REG_MAX_RETRIES:     max_retries   <= cfg_data[7:0];
        REG_SLEEP_WAKE:      sleep_wake_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // poll register
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
    end else if (!in_stall) begin
      poll_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      poll_time <= time_now_ms;
      poll_up   <= upstream_up;
      poll_link <= link_up;
      poll_ok   <= attempt_ok;
    end
  end

  assign due_diff  = poll_time - retry_due_time;
  assign wake_diff = poll_time - mode_entry_time;
  assign fc_base   = wake_clear ? 8'd0 : fail_count;
  assign fc_inc    = (fc_base == 8'hFF) ? fc_base : fc_base + 8'd1;
  assign shift_raw = (fc_inc == 8'd0) ? 8'd0 : fc_inc - 8'd1;
  assign shift     = (shift_raw > SHIFT_MAX) ? SHIFT_MAX : shift_raw;
  assign wide_delay = WIDE_W'(base_delay_ms) << shift;
  assign wide_max   = WIDE_W'(delay_cap_ms);
  assign delay = (wide_delay > wide_max) ? delay_cap_ms : wide_delay[31:0];

  always_comb begin
    attempt    = 1'b0;
    failure    = 1'b0;
    wake_clear = 1'b0;
    if (poll_up) begin
      unique case (mode)
        ST_IDLE:      attempt = !poll_link;
        ST_WAITING:   attempt = !due_diff[31];
        ST_CONNECTED: failure = !poll_link;
        ST_SLEEPING: begin
          if (wake_diff > sleep_wake_ms) begin
            attempt    = 1'b1;
            wake_clear = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_next           = mode;
    fail_count_next     = fail_count;
    retry_due_time_next = retry_due_time;
    joined              = 1'b0;
    delay_out           = 32'd0;
    if (!poll_up) begin
      mode_next = ST_IDLE;
    end else if (attempt && poll_ok) begin
      fail_count_next = 8'd0;
      joined          = 1'b1;
      mode_next       = ST_CONNECTED;
    end else if (attempt || failure) begin
      fail_count_next = fc_inc;
      if (fc_inc >= max_retries) begin
        mode_next = ST_SLEEPING;
      end else begin
        delay_out           = delay;
        retry_due_time_next = poll_time + delay;
        mode_next           = ST_WAITING;
      end
    end
    mode_entry_time_next = (mode_next != mode || attempt) ? poll_time : mode_entry_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= ST_IDLE;
      fail_count      <= 8'd0;
      retry_due_time  <= 32'd0;
      mode_entry_time <= 32'd0;
    end else if (out_load) begin
      mode            <= mode_next;
      fail_count      <= fail_count_next;
      retry_due_time  <= retry_due_time_next;
      mode_entry_time <= mode_entry_time_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      conn_state         <= state_code(mode_next);
      attempt_issued     <= attempt;
      just_connected     <= joined;
      usable             <= (mode_next == ST_CONNECTED) && poll_link;
      retries_done       <= fail_count_next;
      scheduled_delay_ms <= delay_out;
    end
  end

  `RBS_ASSERT_NOW(a_join_shape, clk, rst, out_valid && just_connected,
    attempt_issued && conn_state == CODE_CONNECTED && retries_done == 8'd0)
  `RBS_ASSERT_NOW(a_delay_waits, clk, rst, out_valid && scheduled_delay_ms != 32'd0,
    conn_state == CODE_WAITING)
  `RBS_ASSERT_NOW(a_usable_conn, clk, rst, out_valid && usable,
    conn_state == CODE_CONNECTED)
  `RBS_ASSERT_NEXT(a_load_shows, clk, rst, out_load, out_valid)

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the reconnect backoff supervisor: directed polls, then random phases.
module tb_top;
  import rbs_pkg::*;

  typedef struct packed {
    logic [31:0] time_now;
    logic        up;
    logic        link;
    logic        ok;
  } poll_t;

  typedef struct packed {
    logic [2:0]  state;
    logic        issued;
    logic        joined;
    logic        usable;
    logic [7:0]  fails;
    logic [31:0] delay;
  } status_t;

  typedef struct {
    poll_t   poll;
    bit      typed;
    status_t want;
  } dir_row_t;

  typedef struct {
    logic [31:0] init_ms;
    logic [31:0] cap_ms;
    logic [7:0]  retries;
    logic [31:0] wake_ms;
    int          ok_pct;
    int          aim_pct;
    int          n_polls;
    bit          keep_reset;
    bit          rand_cfg;
  } phase_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_kind_e;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_INITIAL_BACKOFF;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] time_now_ms = '0;
  logic        upstream_up = 1'b0;
  logic        link_up = 1'b0;
  logic        attempt_ok = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  conn_state;
  logic        attempt_issued;
  logic        just_connected;
  logic        usable;
  logic [7:0]  retries_done;
  logic [31:0] scheduled_delay_ms;

  reconnect_backoff_supervisor uut (.*);

  // predictor state and its copy of the registers
  logic [2:0]  sv_mode;
  logic [7:0]  sv_fails;
  logic [31:0] sv_due;
  logic [31:0] sv_entry;
  logic [31:0] set_init;
  logic [31:0] set_cap;
  logic [7:0]  set_retries;
  logic [31:0] set_wake;
  logic [31:0] pr_delay;
  logic        pr_issued;
  logic        pr_joined;

  status_t     pending_status_q[$];
  status_t     got_status;
  status_t     want_status;
  int          mismatch_cnt = 0;
  int          burst_left = 0;
  logic [31:0] now_ms = '0;
  int          stall_left = 0;
  stall_kind_e stall_kind = STALL_NONE;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic enter_mode(input logic [2:0] m, input logic [31:0] now);
    if (sv_mode != m) begin
      sv_mode = m;
      sv_entry = now;
    end
  endtask

  task automatic count_failure(input logic [31:0] now);
    int          shift_amt;
    logic [63:0] wide;
    if (sv_fails != 8'hFF) sv_fails = sv_fails + 8'd1;
    if (sv_fails >= set_retries) begin
      enter_mode(CODE_SLEEPING, now);
    end else begin
      shift_amt = (sv_fails == 0) ? 0 : int'(sv_fails) - 1;
      if (shift_amt > SHIFT_LIMIT_DEFAULT) shift_amt = SHIFT_LIMIT_DEFAULT;
      wide = {32'd0, set_init} << shift_amt;
      if (wide > {32'd0, set_cap}) wide = {32'd0, set_cap};
      pr_delay = wide[31:0];
      sv_due = now + pr_delay;
      enter_mode(CODE_WAITING, now);
    end
  endtask

  task automatic try_connect(input logic [31:0] now, input logic ok);
    enter_mode(CODE_CONNECTING, now);
    pr_issued = 1'b1;
    if (ok) begin
      sv_fails = '0;
      pr_joined = 1'b1;
      enter_mode(CODE_CONNECTED, now);
    end else begin
      count_failure(now);
    end
  endtask

  task automatic supervise_poll(input poll_t p, output status_t s);
    logic [31:0] since;
    pr_delay = '0;
    pr_issued = 1'b0;
    pr_joined = 1'b0;
    if (!p.up) begin
      enter_mode(CODE_IDLE, p.time_now);
    end else begin
      case (sv_mode)
        CODE_IDLE: if (!p.link) try_connect(p.time_now, p.ok);
        CODE_WAITING: begin
          since = p.time_now - sv_due;
          if (!since[31]) try_connect(p.time_now, p.ok);
        end
        CODE_CONNECTED: if (!p.link) count_failure(p.time_now);
        CODE_SLEEPING: begin
          since = p.time_now - sv_entry;
          if (since > set_wake) begin
            sv_fails = '0;
            try_connect(p.time_now, p.ok);
          end
        end
        default: ;
      endcase
    end
    s.state = sv_mode;
    s.issued = pr_issued;
    s.joined = pr_joined;
    s.usable = (sv_mode == CODE_CONNECTED) && p.link;
    s.fails = sv_fails;
    s.delay = pr_delay;
  endtask

  // time steps aim at the retry due time or the wake point much of the time
  task automatic next_poll(input int ok_pct, input int aim_pct, output poll_t p);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < aim_pct && sv_mode == CODE_WAITING)
      now_ms = sv_due + $urandom_range(0, 4) - 32'd2;
    else if (roll < aim_pct && sv_mode == CODE_SLEEPING)
      now_ms = sv_entry + set_wake + $urandom_range(0, 3) - 32'd1;
    else if (roll < 60)
      now_ms = now_ms + $urandom_range(0, 5);
    else if (roll < 80)
      now_ms = now_ms + $urandom_range(0, 65535);
    else if (roll < 95)
      now_ms = now_ms + $urandom;
    else
      now_ms = $urandom;
    p.time_now = now_ms;
    p.up = ($urandom_range(0, 15) != 0);
    p.link = 1'($urandom_range(0, 1));
    p.ok = ($urandom_range(0, 99) < ok_pct);
  endtask

  task automatic offer_poll(input poll_t p, input bit typed, input status_t want);
    int      gap;
    status_t s;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    time_now_ms <= p.time_now;
    upstream_up <= p.up;
    link_up <= p.link;
    attempt_ok <= p.ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    supervise_poll(p, s);
    pending_status_q.push_back(typed ? want : s);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(input phase_t ph);
    logic [1:0] idx;
    for (int i = 0; i < 4; i++) begin
      idx = 2'(i);
      cfg_we <= 1'b1;
      cfg_index <= idx;
      case (idx)
        REG_INITIAL_BACKOFF: begin
          cfg_data <= ph.init_ms;
          set_init = ph.init_ms;
        end
        REG_MAX_BACKOFF: begin
          cfg_data <= ph.cap_ms;
          set_cap = ph.cap_ms;
        end
        REG_MAX_RETRIES: begin
          cfg_data <= {24'd0, ph.retries};
          set_retries = ph.retries;
        end
        default: begin
          cfg_data <= ph.wake_ms;
          set_wake = ph.wake_ms;
        end
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic dir_row_t mk_row(input logic [31:0] t, input logic up, input logic link,
                                      input logic ok, input bit typed, input logic [2:0] st,
                                      input logic iss, input logic jc, input logic us,
                                      input logic [7:0] n, input logic [31:0] d);
    dir_row_t r;
    r.poll = {t, up, link, ok};
    r.typed = typed;
    r.want = {st, iss, jc, us, n, d};
    return r;
  endfunction

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_kind = stall_kind_e'($urandom_range(0, 3));
      stall_left = $urandom_range(32, 256);
    end else begin
      stall_left--;
    end
    case (stall_kind)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ~out_stall;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_status = {conn_state, attempt_issued, just_connected, usable, retries_done,
                    scheduled_delay_ms};
      if (pending_status_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: unexpected status beat st=%0d n=%0d dly=%0d", $time,
                   got_status.state, got_status.fails, got_status.delay);
      end else begin
        want_status = pending_status_q.pop_front();
        if (got_status !== want_status) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: status mismatch want st=%0d att=%b ok=%b use=%b n=%0d dly=%0d",
                     $time, want_status.state, want_status.issued, want_status.joined,
                     want_status.usable, want_status.fails, want_status.delay,
                     "\n          got  st=%0d att=%b ok=%b use=%b n=%0d dly=%0d",
                     got_status.state, got_status.issued, got_status.joined,
                     got_status.usable, got_status.fails, got_status.delay);
        end
      end
    end
  end

  initial begin
    dir_row_t dir_tab[$];
    phase_t   plan[8];
    poll_t    p;
    status_t  none;

    none = '0;
    set_init = INITIAL_BACKOFF_RESET;
    set_cap = MAX_BACKOFF_RESET;
    set_retries = MAX_RETRIES_RESET;
    set_wake = SLEEP_WAKE_RESET;
    sv_mode = CODE_IDLE;
    sv_fails = '0;
    sv_due = '0;
    sv_entry = '0;

    // default registers: backoff ladder, sleep, wake edge, wrap of the due time
    dir_tab.push_back(mk_row(32'd0, 0, 0, 0, 1, CODE_IDLE, 0, 0, 0, 8'd0, 32'd0));
    dir_tab.push_back(mk_row(32'd10, 1, 1, 1, 1, CODE_IDLE, 0, 0, 0, 8'd0, 32'd0));
    dir_tab.push_back(mk_row(32'd20, 1, 0, 0, 1, CODE_WAITING, 1, 0, 0, 8'd1, 32'd2000));
    dir_tab.push_back(mk_row(32'd2019, 1, 0, 1, 1, CODE_WAITING, 0, 0, 0, 8'd1, 32'd0));
    dir_tab.push_back(mk_row(32'd2020, 1, 0, 0, 1, CODE_WAITING, 1, 0, 0, 8'd2, 32'd4000));
    dir_tab.push_back(mk_row(32'd6020, 1, 0, 0, 1, CODE_WAITING, 1, 0, 0, 8'd3, 32'd8000));
    dir_tab.push_back(mk_row(32'd14020, 1, 0, 0, 1, CODE_WAITING, 1, 0, 0, 8'd4, 32'd16000));
    dir_tab.push_back(mk_row(32'd30020, 1, 0, 0, 1, CODE_SLEEPING, 1, 0, 0, 8'd5, 32'd0));
    dir_tab.push_back(mk_row(32'd330020, 1, 0, 1, 1, CODE_SLEEPING, 0, 0, 0, 8'd5, 32'd0));
    dir_tab.push_back(mk_row(32'd330021, 1, 0, 1, 1, CODE_CONNECTED, 1, 1, 0, 8'd0, 32'd0));
    dir_tab.push_back(mk_row(32'd330022, 1, 1, 0, 1, CODE_CONNECTED, 0, 0, 1, 8'd0, 32'd0));
    dir_tab.push_back(mk_row(32'd330030, 1, 0, 0, 1, CODE_WAITING, 0, 0, 0, 8'd1, 32'd2000));
    dir_tab.push_back(mk_row(32'd332030, 1, 1, 1, 1, CODE_CONNECTED, 1, 1, 1, 8'd0, 32'd0));
    dir_tab.push_back(mk_row(32'd332040, 0, 1, 1, 1, CODE_IDLE, 0, 0, 0, 8'd0, 32'd0));
    dir_tab.push_back(mk_row(32'hFFFFFFF0, 1, 0, 0, 1, CODE_WAITING, 1, 0, 0, 8'd1, 32'd2000));
    dir_tab.push_back(mk_row(32'h000007BF, 1, 0, 1, 1, CODE_WAITING, 0, 0, 0, 8'd1, 32'd0));
    dir_tab.push_back(mk_row(32'h000007C0, 1, 1, 1, 1, CODE_CONNECTED, 1, 1, 1, 8'd0, 32'd0));
    dir_tab.push_back(mk_row(32'h80000000, 1, 1, 0, 1, CODE_CONNECTED, 0, 0, 1, 8'd0, 32'd0));
    dir_tab.push_back(mk_row(32'hFFFFFFFF, 0, 1, 1, 1, CODE_IDLE, 0, 0, 0, 8'd0, 32'd0));
    dir_tab.push_back(mk_row(32'd100, 1, 0, 0, 1, CODE_WAITING, 1, 0, 0, 8'd1, 32'd2000));
    dir_tab.push_back(mk_row(32'd101, 0, 0, 0, 1, CODE_IDLE, 0, 0, 0, 8'd1, 32'd0));
    dir_tab.push_back(mk_row(32'd102, 1, 0, 0, 0, CODE_IDLE, 0, 0, 0, 8'd0, 32'd0));
    dir_tab.push_back(mk_row(32'd4102, 1, 1, 0, 0, CODE_IDLE, 0, 0, 0, 8'd0, 32'd0));

    plan[0] = '{INITIAL_BACKOFF_RESET, MAX_BACKOFF_RESET, MAX_RETRIES_RESET, SLEEP_WAKE_RESET,
                30, 40, 200, 1'b1, 1'b0};
    plan[1] = '{32'd1, 32'd1, 8'd1, 32'd0, 30, 40, 200, 1'b0, 1'b0};
    // long failure streaks: count runs up to the top and saturates
    plan[2] = '{32'd1, 32'hFFFFFFFF, 8'd255, 32'd50, 1, 90, 700, 1'b0, 1'b0};
    plan[3] = '{32'hFFFFFFFF, 32'hFFFFFFFF, 8'd8, 32'hFFFFFFFF, 20, 40, 200, 1'b0, 1'b0};
    plan[4] = '{32'h80000000, 32'hFFFFFFFF, 8'd3, 32'd1000, 20, 40, 150, 1'b0, 1'b0};
    plan[5] = '{32'd3000, 32'd20000, 8'd0, 32'hFFFFFFFE, 25, 50, 150, 1'b0, 1'b0};
    plan[6] = '{32'd0, 32'd0, 8'd0, 32'd0, 25, 40, 200, 1'b0, 1'b1};
    plan[7] = '{32'd0, 32'd0, 8'd0, 32'd0, 25, 40, 200, 1'b0, 1'b1};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) offer_poll(dir_tab[i].poll, dir_tab[i].typed, dir_tab[i].want);
    now_ms = dir_tab[dir_tab.size() - 1].poll.time_now;

    foreach (plan[ph]) begin
      if (!plan[ph].keep_reset) begin
        if (plan[ph].rand_cfg) begin
          plan[ph].init_ms = $urandom >> $urandom_range(0, 31);
          if (plan[ph].init_ms == 0) plan[ph].init_ms = 32'd1;
          plan[ph].cap_ms = $urandom >> $urandom_range(0, 31);
          if (plan[ph].cap_ms == 0) plan[ph].cap_ms = 32'd1;
          plan[ph].retries = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                         : 8'($urandom_range(1, 12));
          plan[ph].wake_ms = $urandom >> $urandom_range(0, 31);
        end
        drain();
        load_settings(plan[ph]);
      end
      for (int n = 0; n < plan[ph].n_polls; n++) begin
        next_poll(plan[ph].ok_pct, plan[ph].aim_pct, p);
        offer_poll(p, 1'b0, none);
      end
    end

    drain();
    if (mismatch_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/rbs_pkg.sv
src/reconnect_backoff_supervisor.sv
test/tb_top.sv
